// File: hdl/cmp_pkg.sv
// ----------------------------------------------------------------------------
// cmp_pkg
// Shared types and constants for the CoAP message parser: byte classes,
// parse phases, status codes and the parser state and result records.
// ----------------------------------------------------------------------------
package cmp_pkg;

    localparam int MAX_TOKEN_BYTES = 8;

    // byte class codes
    localparam logic [2:0] CLS_HEADER = 3'd0;
    localparam logic [2:0] CLS_TOKEN  = 3'd1;
    localparam logic [2:0] CLS_OPT    = 3'd2;
    localparam logic [2:0] CLS_EXT    = 3'd3;
    localparam logic [2:0] CLS_VALUE  = 3'd4;
    localparam logic [2:0] CLS_MARKER = 3'd5;
    localparam logic [2:0] CLS_PAY    = 3'd6;
    localparam logic [2:0] CLS_DISC   = 3'd7;

    // parse phase codes; header phase is the all-zero code
    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_TOK  = 3'd1;
    localparam logic [2:0] PH_OPT  = 3'd2;
    localparam logic [2:0] PH_DEXT = 3'd3;
    localparam logic [2:0] PH_LEXT = 3'd4;
    localparam logic [2:0] PH_VAL  = 3'd5;
    localparam logic [2:0] PH_PAY  = 3'd6;
    localparam logic [2:0] PH_DISC = 3'd7;

    // status codes
    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [7:0]  C_MARKER      = 8'hFF;
    localparam logic [1:0]  C_VERSION     = 2'd1;
    localparam logic [3:0]  C_NIB_EXT1    = 4'd13;
    localparam logic [3:0]  C_NIB_RSVD    = 4'd15;
    localparam logic [16:0] C_EXT1_BASE   = 17'd13;
    localparam logic [16:0] C_EXT2_BASE   = 17'd269;
    localparam logic [17:0] C_OPT_NUM_MAX = 18'd65535;
    localparam logic [3:0]  C_TKL_MAX     = 4'(MAX_TOKEN_BYTES);

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  byte_cnt;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  tok_len;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic [63:0] token_value;
        logic [3:0]  token_left;
        logic [15:0] option_sum;
        logic [3:0]  delta_nib;
        logic [3:0]  length_nib;
        logic [15:0] ext_acc;
        logic [16:0] value_left;
        logic [7:0]  option_count;
        logic        error;
        logic        option_seen;
        logic [16:0] cur_length;
    } t_state;

    // packed from the top bit down; byte_class lands in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [1:0]  status;
        logic        option_done;
        logic [16:0] opt_len;
        logic [15:0] opt_num;
        logic [7:0]  option_index;
        logic [63:0] token_value;
        logic [15:0] message_id;
        logic [7:0]  code;
        logic [3:0]  tok_len;
        logic [1:0]  msg_type;
        logic [1:0]  version;
        logic [2:0]  byte_class;
    } t_result;

endpackage

// File: hdl/cmp_decode.sv
// ----------------------------------------------------------------------------
// cmp_decode
// Next-state and result logic for one message byte: classifies the byte,
// updates header, token and option tracking, and forms the status.
// ----------------------------------------------------------------------------
module cmp_decode (
    input  cmp_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output cmp_pkg::t_state  o_state,
    output cmp_pkg::t_result o_result
);

    cmp_pkg::t_state n;
    logic [2:0]  cls;
    logic        done;
    logic        do_delta;
    logic        do_finish;
    logic [16:0] delta_val;
    logic [16:0] len_val;
    logic [17:0] sum;
    logic [15:0] ext_new;
    logic        valid_end;
    logic [1:0]  status;

    assign ext_new = {i_state.ext_acc[7:0], i_byte};

    always_comb begin
        n         = i_state;
        cls       = cmp_pkg::CLS_DISC;
        done      = 1'b0;
        do_delta  = 1'b0;
        do_finish = 1'b0;
        delta_val = '0;
        len_val   = '0;
        sum       = '0;

        case (i_state.phase)
            cmp_pkg::PH_HDR: begin
                cls = cmp_pkg::CLS_HEADER;
                case (i_state.byte_cnt)
                    2'd0: begin
                        n.version      = i_byte[7:6];
                        n.msg_type     = i_byte[5:4];
                        n.tok_len      = i_byte[3:0];
                        n.code         = '0;
                        n.message_id   = '0;
                        if (i_byte[7:6] != cmp_pkg::C_VERSION ||
                            i_byte[3:0] > cmp_pkg::C_TKL_MAX) begin
                            n.error = 1'b1;
                            n.phase = cmp_pkg::PH_DISC;
                        end else begin
                            n.token_left = i_byte[3:0];
                            n.byte_cnt   = 2'd1;
                        end
                    end
                    2'd1: begin
                        n.code     = i_byte;
                        n.byte_cnt = 2'd2;
                    end
                    2'd2: begin
                        n.message_id[15:8] = i_byte;
                        n.byte_cnt         = 2'd3;
                    end
                    default: begin
                        n.message_id[7:0] = i_byte;
                        n.byte_cnt        = 2'd0;
                        n.phase = (i_state.token_left != '0) ? cmp_pkg::PH_TOK
                                                             : cmp_pkg::PH_OPT;
                    end
                endcase
            end
            cmp_pkg::PH_TOK: begin
                cls           = cmp_pkg::CLS_TOKEN;
                n.token_value = {i_state.token_value[55:0], i_byte};
                n.token_left  = i_state.token_left - 4'd1;
                if (n.token_left == '0) begin
                    n.phase = cmp_pkg::PH_OPT;
                end
            end
            cmp_pkg::PH_OPT: begin
                if (i_byte == cmp_pkg::C_MARKER) begin
                    cls     = cmp_pkg::CLS_MARKER;
                    n.phase = cmp_pkg::PH_PAY;
                end else begin
                    cls = cmp_pkg::CLS_OPT;
                    // first option keeps index zero, later ones count up to 255
                    if (i_state.option_seen) begin
                        if (i_state.option_count != 8'hFF) begin
                            n.option_count = i_state.option_count + 8'd1;
                        end
                    end else begin
                        n.option_seen = 1'b1;
                    end
                    n.delta_nib  = i_byte[7:4];
                    n.length_nib = i_byte[3:0];
                    if (i_byte[7:4] == cmp_pkg::C_NIB_RSVD ||
                        i_byte[3:0] == cmp_pkg::C_NIB_RSVD) begin
                        n.error = 1'b1;
                        n.phase = cmp_pkg::PH_DISC;
                    end else if (i_byte[7:4] < cmp_pkg::C_NIB_EXT1) begin
                        do_delta  = 1'b1;
                        delta_val = {13'd0, i_byte[7:4]};
                    end else begin
                        n.ext_acc  = '0;
                        n.byte_cnt = (i_byte[7:4] == cmp_pkg::C_NIB_EXT1) ? 2'd1 : 2'd2;
                        n.phase    = cmp_pkg::PH_DEXT;
                    end
                end
            end
            cmp_pkg::PH_DEXT: begin
                cls        = cmp_pkg::CLS_EXT;
                n.ext_acc  = ext_new;
                n.byte_cnt = i_state.byte_cnt - 2'd1;
                if (n.byte_cnt == '0) begin
                    do_delta  = 1'b1;
                    delta_val = {1'b0, ext_new} +
                                ((i_state.delta_nib == cmp_pkg::C_NIB_EXT1) ?
                                 cmp_pkg::C_EXT1_BASE : cmp_pkg::C_EXT2_BASE);
                end
            end
            cmp_pkg::PH_LEXT: begin
                cls        = cmp_pkg::CLS_EXT;
                n.ext_acc  = ext_new;
                n.byte_cnt = i_state.byte_cnt - 2'd1;
                if (n.byte_cnt == '0) begin
                    do_finish = 1'b1;
                    len_val   = {1'b0, ext_new} +
                                ((i_state.length_nib == cmp_pkg::C_NIB_EXT1) ?
                                 cmp_pkg::C_EXT1_BASE : cmp_pkg::C_EXT2_BASE);
                end
            end
            cmp_pkg::PH_VAL: begin
                cls          = cmp_pkg::CLS_VALUE;
                n.value_left = i_state.value_left - 17'd1;
                if (n.value_left == '0) begin
                    n.phase = cmp_pkg::PH_OPT;
                end
            end
            cmp_pkg::PH_PAY: begin
                cls = cmp_pkg::CLS_PAY;
            end
            default: begin
                cls = cmp_pkg::CLS_DISC;
            end
        endcase

        // add the delta to the running option number
        if (do_delta) begin
            sum = {2'd0, i_state.option_sum} + {1'b0, delta_val};
            if (sum > cmp_pkg::C_OPT_NUM_MAX) begin
                n.option_sum = 16'hFFFF;
                n.error      = 1'b1;
                n.phase      = cmp_pkg::PH_DISC;
            end else begin
                n.option_sum = sum[15:0];
                if (n.length_nib < cmp_pkg::C_NIB_EXT1) begin
                    do_finish = 1'b1;
                    len_val   = {13'd0, n.length_nib};
                end else begin
                    n.ext_acc  = '0;
                    n.byte_cnt = (n.length_nib == cmp_pkg::C_NIB_EXT1) ? 2'd1 : 2'd2;
                    n.phase    = cmp_pkg::PH_LEXT;
                end
            end
        end

        if (do_finish) begin
            n.cur_length = len_val;
            n.value_left = len_val;
            done         = 1'b1;
            n.phase      = (len_val != '0) ? cmp_pkg::PH_VAL : cmp_pkg::PH_OPT;
        end

        valid_end = (n.phase == cmp_pkg::PH_OPT) ||
                    (n.phase == cmp_pkg::PH_PAY && cls == cmp_pkg::CLS_PAY);
        if (n.error) begin
            status = cmp_pkg::ST_INVALID;
        end else if (i_last) begin
            status = valid_end ? cmp_pkg::ST_OK : cmp_pkg::ST_INVALID;
        end else begin
            status = cmp_pkg::ST_BUSY;
        end

        o_result.pad           = 1'b0;
        o_result.status        = status;
        o_result.option_done   = done;
        o_result.opt_len       = n.cur_length;
        o_result.opt_num       = n.option_sum;
        o_result.option_index  = n.option_count;
        o_result.token_value   = n.token_value;
        o_result.message_id    = n.message_id;
        o_result.code          = n.code;
        o_result.tok_len       = n.tok_len;
        o_result.msg_type      = n.msg_type;
        o_result.version       = n.version;
        o_result.byte_class    = cls;

        // final byte: start the next message from a clean state
        o_state = i_last ? '0 : n;
    end

endmodule

// File: hdl/coap_message_parser_unit.sv
// ----------------------------------------------------------------------------
// coap_message_parser_unit
// Byte-stream CoAP message parser with one result per input byte.
// ----------------------------------------------------------------------------
// Takes one byte per transfer, at a rate of one byte per clock cycle while
// the output is not stalled, and returns exactly one result per byte in the
// next cycle. The parse state is updated in the same cycle the byte is taken,
// and the result sits in an output register, so the next byte is taken while
// a result waits as long as the downstream side takes it in the same cycle.
// Throughput is set by that single output register: one byte per cycle when
// the output is never stalled. A byte with tlast high ends the message and
// the parser returns to its reset state for the next one.
module coap_message_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tlast,   // last_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [2:0] byte_class, [4:3] version, [6:5] msg_type, [10:7] tok_len,
    // [18:11] code, [34:19] message_id, [98:35] token_value,
    // [106:99] option_index, [122:107] opt_num,
    // [139:123] opt_len, [140] option_done, [142:141] status, [143] zero
    output logic [143:0] o_m_axis_tdata
);

    cmp_pkg::t_state  r_state;
    cmp_pkg::t_state  n_state;
    cmp_pkg::t_result r_result;
    cmp_pkg::t_result n_result;
    logic             r_out_valid;
    logic             w_accept;

    cmp_decode u_decode (
        .i_state  (r_state),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;   // header phase, all fields clear
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_result;

endmodule
